// ===== src/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg
// shared widths, field layout and request codes of the sorted insertion list
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // request kind carried in req_tuser
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   // rsp_tuser bit positions
   localparam int FLAG_EMPTY   = 0;
   localparam int FLAG_DROPPED = 1;

endpackage

// ===== src/sli_ram.sv =====
// ----------------------------------------------------------------------------
// sli_ram
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module sli_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [sli_pkg::VALUE_W-1:0]   wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [sli_pkg::VALUE_W-1:0]   rd_data
);

   logic [sli_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [sli_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sorted_list_insert_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_top
// bounded ascending list of signed values with insert and read-out requests
// ----------------------------------------------------------------------------
// insert: one compare and one ram write per entry shifted up, then the result beat;
//   into an empty list the value is written directly, and when full it is dropped
// read: each value beat is loaded through the registered ram read port;
//   an empty read gives a single beat with no ram read
// one request at a time; the next one is taken after the last beat leaves
// reset clears the entry count and the sequencer; the store is not cleared
// ----------------------------------------------------------------------------
module sorted_list_insert_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sli_pkg::REQ_TDATA_W-1:0]  req_tdata,  // value[31:0]
   input  logic                             req_tuser,  // mode[0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sli_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // item_value[31:0], entry_count[36:32]
   output logic                             rsp_tlast,  // last_item
   output logic [sli_pkg::RSP_TUSER_W-1:0]  rsp_tuser   // list_empty[0], dropped_full[1]
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_RD_ISSUE,
      ST_RD_LOAD,
      ST_RESP
   } state_type;

   state_type                       state_ff;
   logic [CW-1:0]                   count_ff;
   logic [AW-1:0]                   idx_ff;
   logic [AW-1:0]                   rd_idx_ff;
   logic                            mode_ff;
   logic signed [sli_pkg::VALUE_W-1:0] value_ff;
   logic [sli_pkg::VALUE_W-1:0]     item_ff;
   logic                            last_ff;
   logic                            empty_ff;
   logic                            dropped_ff;
   logic [CW-1:0]                   rsp_count_ff;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [sli_pkg::VALUE_W-1:0]     wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [sli_pkg::VALUE_W-1:0]     rd_data;
   logic                            shift_up;
   logic [AW-1:0]                   last_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {{(sli_pkg::RSP_TDATA_W - sli_pkg::VALUE_W - sli_pkg::COUNT_W){1'b0}},
                        sli_pkg::COUNT_W'(rsp_count_ff), item_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {dropped_ff, empty_ff};

   assign shift_up = ($signed(rd_data) > value_ff);
   assign last_idx = AW'(count_ff - 1'b1);

   sli_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = value_ff;
      rd_addr = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_tuser == sli_pkg::MODE_READ) ? '0 : last_idx;
            if (req_tvalid && (req_tuser == sli_pkg::MODE_INSERT) && (count_ff == '0)) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = req_tdata;
            end
         end
         ST_INS_CMP: begin
            rd_addr = AW'(idx_ff - 2'd2);
            wr_en   = 1'b1;
            wr_data = shift_up ? rd_data : value_ff;
         end
         ST_INS_PUT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  mode_ff    <= req_tuser;
                  value_ff   <= $signed(req_tdata);
                  item_ff    <= '0;
                  last_ff    <= 1'b1;
                  empty_ff   <= 1'b0;
                  dropped_ff <= 1'b0;
                  rsp_count_ff <= count_ff;
                  if (req_tuser == sli_pkg::MODE_READ) begin
                     rd_idx_ff <= '0;
                     if (count_ff == '0) begin
                        empty_ff <= 1'b1;
                        state_ff <= ST_RESP;
                     end else begin
                        state_ff <= ST_RD_LOAD;
                     end
                  end else if (count_ff == CW'(MAX_ENTRIES)) begin
                     dropped_ff <= 1'b1;
                     state_ff   <= ST_RESP;
                  end else if (count_ff == '0) begin
                     count_ff     <= CW'(1);
                     rsp_count_ff <= CW'(1);
                     state_ff     <= ST_RESP;
                  end else begin
                     idx_ff   <= AW'(count_ff);
                     state_ff <= ST_INS_CMP;
                  end
               end
            end
            ST_INS_CMP: begin
               if (shift_up) begin
                  idx_ff <= AW'(idx_ff - 1'b1);
                  if (idx_ff == AW'(1)) begin
                     state_ff <= ST_INS_PUT;
                  end
               end else begin
                  count_ff     <= CW'(count_ff + 1'b1);
                  rsp_count_ff <= CW'(count_ff + 1'b1);
                  state_ff     <= ST_RESP;
               end
            end
            ST_INS_PUT: begin
               count_ff     <= CW'(count_ff + 1'b1);
               rsp_count_ff <= CW'(count_ff + 1'b1);
               state_ff     <= ST_RESP;
            end
            ST_RD_ISSUE: begin
               state_ff <= ST_RD_LOAD;
            end
            ST_RD_LOAD: begin
               item_ff  <= rd_data;
               last_ff  <= (rd_idx_ff == last_idx);
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  if ((mode_ff == sli_pkg::MODE_READ) && !last_ff) begin
                     rd_idx_ff <= AW'(rd_idx_ff + 1'b1);
                     state_ff  <= ST_RD_ISSUE;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/sli_checker.sv =====
// ----------------------------------------------------------------------------
// sli_checker
// port-level checks of the sorted insertion list, bound to the top level
// ----------------------------------------------------------------------------
module sli_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sli_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic [sli_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   // empty read is a single zero beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[sli_pkg::FLAG_EMPTY] |->
         rsp_tlast && (rsp_tdata == '0) && !rsp_tuser[sli_pkg::FLAG_DROPPED])
      else $error("empty read beat malformed");

   // dropped insert gives one beat with no value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[sli_pkg::FLAG_DROPPED] |->
         rsp_tlast && (rsp_tdata[sli_pkg::VALUE_W-1:0] == '0))
      else $error("dropped insert beat malformed");

   // no new request taken while a beat is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

endmodule

bind sorted_list_insert_top sli_checker u_sli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_sorted_list_insert_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_top
// self-checking bench for the bounded ascending list: inserts and read-outs
// are predicted by a scoreboard with its own sorted copy of the store, and
// every response beat is compared field by field under random idling on both
// stream sides, with one long response hold-off that backs up the request side
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_top;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 300;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 100;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct packed {
      logic [sli_pkg::VALUE_W-1:0] item_value;
      logic                        last_item;
      logic                        list_empty;
      logic                        dropped_full;
      logic [sli_pkg::COUNT_W-1:0] entry_count;
   } list_beat_type;

   class sorted_list_scoreboard;
      int            capacity;
      int            sorted_values[$];
      list_beat_type awaited_beats[$];
      int            beat_index;
      int            error_count;

      function new(int capacity_i);
         capacity    = capacity_i;
         beat_index  = 0;
         error_count = 0;
      endfunction

      function int stored();
         return sorted_values.size();
      endfunction

      function int outstanding();
         return awaited_beats.size();
      endfunction

      task report(string msg);
         if (error_count < 40) begin
            $display("mismatch: beat %0d %s", beat_index, msg);
         end
         error_count++;
      endtask

      task compare_field(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s got %0h want %0h", field, got, want));
         end
      endtask

      // new values go after any stored equal ones
      function void note_request(logic mode, logic [31:0] value);
         list_beat_type beat;
         int            n;
         int            slot;
         int            v;
         n    = sorted_values.size();
         v    = value;
         beat = '0;
         beat.last_item   = 1'b1;
         beat.entry_count = n[sli_pkg::COUNT_W-1:0];
         if (mode == sli_pkg::MODE_INSERT) begin
            if (n >= capacity) begin
               beat.dropped_full = 1'b1;
            end else begin
               slot = n;
               for (int i = 0; i < n; i++) begin
                  if (sorted_values[i] > v) begin
                     slot = i;
                     break;
                  end
               end
               sorted_values.insert(slot, v);
               beat.entry_count = sli_pkg::COUNT_W'(n + 1);
            end
            awaited_beats.push_back(beat);
         end else if (n == 0) begin
            beat.list_empty = 1'b1;
            awaited_beats.push_back(beat);
         end else begin
            for (int i = 0; i < n; i++) begin
               beat.item_value = sorted_values[i];
               beat.last_item  = (i == n - 1);
               awaited_beats.push_back(beat);
            end
         end
      endfunction

      task check_beat(list_beat_type seen);
         list_beat_type want;
         if (awaited_beats.size() == 0) begin
            report("arrived with nothing awaited");
         end else begin
            want = awaited_beats.pop_front();
            compare_field("item_value", seen.item_value, want.item_value);
            compare_field("last_item", 32'(seen.last_item), 32'(want.last_item));
            compare_field("list_empty", 32'(seen.list_empty), 32'(want.list_empty));
            compare_field("dropped_full", 32'(seen.dropped_full), 32'(want.dropped_full));
            compare_field("entry_count", 32'(seen.entry_count), 32'(want.entry_count));
         end
         beat_index++;
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [sli_pkg::REQ_TDATA_W-1:0] req_tdata;   // value[31:0]
   logic                            req_tuser;   // mode[0]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [sli_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // item_value[31:0], entry_count[36:32]
   logic                            rsp_tlast;   // last_item
   logic [sli_pkg::RSP_TUSER_W-1:0] rsp_tuser;   // list_empty[0], dropped_full[1]

   sorted_list_scoreboard list_check;
   bit                    hold_request = 1'b0;
   int                    cycle_count  = 0;

   sorted_list_insert_top #(
      .MAX_ENTRIES(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_sorted_list_insert_top: done, errors");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int roll;
      if (quiet) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // extremes, values near zero to force equal keys, and full-range values
   function automatic logic [31:0] pick_value();
      int roll;
      int near;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (roll < 4) begin
         near = $urandom_range(0, 8);
         return near - 4;
      end
      return $urandom;
   endfunction

   task automatic send_request(logic mode, logic [31:0] value, bit quiet);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      list_check.note_request(mode, value);
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : receive_beats
      list_beat_type seen;
      int            stall;
      int            taken;
      bit            held;
      taken = 0;
      held  = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = pick_gap((taken / 50) % 3 == 2);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         seen.item_value   = rsp_tdata[sli_pkg::VALUE_W-1:0];
         seen.entry_count  = rsp_tdata[sli_pkg::VALUE_W +: sli_pkg::COUNT_W];
         seen.last_item    = rsp_tlast;
         seen.list_empty   = rsp_tuser[sli_pkg::FLAG_EMPTY];
         seen.dropped_full = rsp_tuser[sli_pkg::FLAG_DROPPED];
         list_check.check_beat(seen);
         taken++;
      end
   end

   initial begin : drive_requests
      int n_item;
      bit want_read;
      list_check = new(CAPACITY);
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= sli_pkg::MODE_INSERT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty reads, the value bits of a read are don't-care
      send_request(sli_pkg::MODE_READ, 32'h0000_0000, 1'b1);
      send_request(sli_pkg::MODE_READ, 32'hFFFF_FFFF, 1'b1);
      // extremes and equal keys
      send_request(sli_pkg::MODE_INSERT, 32'h0000_0000, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'h8000_0000, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b1);
      send_request(sli_pkg::MODE_READ, 32'h5555_5555, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'h0000_0000, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'h8000_0000, 1'b1);
      send_request(sli_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b1);
      send_request(sli_pkg::MODE_READ, 32'hAAAA_AAAA, 1'b1);

      // fill up with reads in between, then drops and full read-outs
      for (n_item = 0; n_item < RANDOM_ITEMS; n_item++) begin
         if (n_item == 60) begin
            hold_request = 1'b1;
         end
         if (list_check.stored() < CAPACITY) begin
            want_read = ($urandom_range(0, 1) == 1);
         end else begin
            want_read = ($urandom_range(0, 3) == 0);
         end
         send_request(want_read ? sli_pkg::MODE_READ : sli_pkg::MODE_INSERT, pick_value(),
                      (n_item / 32) % 3 == 1);
      end
      req_tvalid <= 1'b0;

      while (list_check.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (list_check.error_count == 0) begin
         $display("tb_sorted_list_insert_top: done, clean");
      end else begin
         $display("tb_sorted_list_insert_top: done, errors");
      end
      $finish;
   end

endmodule
